FILE: sv/plmr_pkg.sv
// ----------------------------------------------------------------------------
// plmr_pkg
// Shared types and constants for the posting list merge and rank block.
// ----------------------------------------------------------------------------
package plmr_pkg;

    localparam int unsigned MaxEntriesDefault = 64;
    localparam int unsigned IdW               = 32;
    localparam int unsigned WtW               = 32;
    localparam int unsigned QueueDepth        = 2;

    typedef enum logic {
        FUNC_MERGE = 1'b0,
        FUNC_EMIT  = 1'b1
    } t_func;

    typedef struct packed {
        logic           func;
        logic [IdW-1:0] doc_id;
        logic [WtW-1:0] weight;
    } t_in_item;

    typedef struct packed {
        logic           entry_valid;
        logic [IdW-1:0] ranked_doc_id;
        logic [WtW-1:0] ranked_weight;
        logic           last;
        logic           overflow;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESP,
        ST_SCAN
    } t_state;

    // 3 * (a + b), saturated to 32 bits
    function automatic logic [WtW-1:0] sat_combine(input logic [WtW-1:0] a,
                                                   input logic [WtW-1:0] b);
        logic [WtW:0]   s;
        logic [WtW+2:0] p;
        s = {1'b0, a} + {1'b0, b};
        p = {2'b00, s} + {1'b0, s, 1'b0};
        return (p[WtW+2:WtW] != 3'd0) ? {WtW{1'b1}} : p[WtW-1:0];
    endfunction

endpackage

FILE: sv/plmr_if.sv
// ----------------------------------------------------------------------------
// plmr_in_if / plmr_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface plmr_in_if;
    logic                valid;
    logic                ready;
    plmr_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface plmr_out_if;
    logic                valid;
    logic                ready;
    plmr_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/posting_list_merge_rank_top.sv
// Order: a merge passes through the front queue and then the registered result;
// an emit of N entries gives N results, one a cycle while the output is not stalled,
// from the single max-select unit that walks the store one entry per cycle; the
// back end finishes one transaction before it takes the next.
// Reset: synchronous active-low i_rst_n empties the queue and the store.
// ----------------------------------------------------------------------------
// posting_list_merge_rank_top
// Sorted posting merge with weight ranking: queue front end, store back end.
// ----------------------------------------------------------------------------
module posting_list_merge_rank_top #(
    parameter int unsigned MAX_ENTRIES = plmr_pkg::MaxEntriesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plmr_in_if.sink     s_in,
    plmr_out_if.source  m_out
);
    logic               q_valid, q_pop;
    plmr_pkg::t_in_item q_item;

    plmr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_in      (s_in),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    plmr_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .m_out     (m_out)
    );
endmodule

FILE: sv/plmr_front.sv
// ----------------------------------------------------------------------------
// plmr_front
// Accepts input transactions into a short queue for the back end.
// ----------------------------------------------------------------------------
module plmr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    plmr_in_if.sink              s_in,
    output logic                 o_q_valid,
    output plmr_pkg::t_in_item   o_q_item,
    input  logic                 i_q_pop
);
    localparam int unsigned D = plmr_pkg::QueueDepth;

    plmr_pkg::t_in_item r_mem [D];
    logic               r_wp, r_rp;
    logic [1:0]         r_cnt;
    logic               push;

    assign s_in.ready = (r_cnt != 2'(D));
    assign push       = s_in.valid && s_in.ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= s_in.data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push)    r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(D)) else $error("queue count overrun");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(D)) |-> !s_in.ready) else $error("ready while full");
`endif
endmodule

FILE: sv/plmr_back.sv
// ----------------------------------------------------------------------------
// plmr_back
// Sorted register store with parallel compare insert; emit by repeated
// max selection that takes the lowest index among equal weights.
// ----------------------------------------------------------------------------
module plmr_back #(
    parameter int unsigned MAX_ENTRIES = plmr_pkg::MaxEntriesDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  plmr_pkg::t_in_item   i_q_item,
    output logic                 o_q_pop,
    plmr_out_if.source           m_out
);
    localparam int unsigned IW = $clog2(MAX_ENTRIES);
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned IdW = plmr_pkg::IdW;
    localparam int unsigned WtW = plmr_pkg::WtW;
    // leaves of the max-select tree, padded to a power of two
    localparam int unsigned P  = 1 << IW;

    logic [IdW-1:0] r_doc [MAX_ENTRIES];
    logic [WtW-1:0] r_wt  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_used;   // set when an entry has been emitted
    logic [CW-1:0]  r_cnt, r_left;
    plmr_pkg::t_state r_st, n_st;
    plmr_pkg::t_out_item r_out, n_out;

    logic [MAX_ENTRIES-1:0] lt, eq, live;
    logic                   hit;
    logic [IW-1:0]          hit_idx, best_idx;
    logic [WtW-1:0]         best_w;
    logic                   full, do_merge, do_ins, take;

    // heap-ordered tree: node n has children 2n (lower indexes) and 2n+1
    logic [P-1:0]           cand;
    logic [WtW-1:0]         tw [2*P];
    logic [IW-1:0]          ti [2*P];
    logic                   tv [2*P];

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            live[i] = (CW'(i) < r_cnt);
            lt[i]   = live[i] && (r_doc[i] < i_q_item.doc_id);
            eq[i]   = live[i] && (r_doc[i] == i_q_item.doc_id);
        end
        hit     = |eq;
        hit_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (eq[i]) hit_idx = IW'(i);
        end
    end

    // highest weight, lowest index on ties; not yet emitted
    always_comb begin
        cand                  = '0;
        cand[MAX_ENTRIES-1:0] = live & ~r_used;
        tw[0] = '0;
        ti[0] = '0;
        tv[0] = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            tw[P+i] = r_wt[i];
        end
        for (int i = MAX_ENTRIES; i < P; i++) begin
            tw[P+i] = '0;
        end
        for (int i = 0; i < P; i++) begin
            ti[P+i] = IW'(i);
            tv[P+i] = cand[i];
        end
        for (int n = P - 1; n >= 1; n--) begin
            if (tv[2*n] && (!tv[2*n+1] || tw[2*n] >= tw[2*n+1])) begin
                tw[n] = tw[2*n];
                ti[n] = ti[2*n];
            end else begin
                tw[n] = tw[2*n+1];
                ti[n] = ti[2*n+1];
            end
            tv[n] = tv[2*n] || tv[2*n+1];
        end
        best_w   = tw[1];
        best_idx = ti[1];
    end

    assign full  = (r_cnt == CW'(MAX_ENTRIES));
    assign take  = !m_out.valid || m_out.ready;

    always_comb begin
        n_st     = r_st;
        n_out    = r_out;
        o_q_pop  = 1'b0;
        do_merge = 1'b0;
        do_ins   = 1'b0;
        unique case (r_st)
            plmr_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.func == plmr_pkg::FUNC_MERGE) begin
                        o_q_pop  = 1'b1;
                        do_merge = hit;
                        do_ins   = !hit && !full;
                        n_out    = '{1'b0, '0, '0, 1'b1, !hit && full};
                        n_st     = plmr_pkg::ST_RESP;
                    end else if (r_cnt == '0) begin
                        o_q_pop = 1'b1;
                        n_out   = '{1'b0, '0, '0, 1'b1, 1'b0};
                        n_st    = plmr_pkg::ST_RESP;
                    end else begin
                        n_st = plmr_pkg::ST_SCAN;
                    end
                end
            end
            plmr_pkg::ST_RESP: begin
                if (take) n_st = plmr_pkg::ST_IDLE;
            end
            plmr_pkg::ST_SCAN: begin
                if (take) begin
                    n_out = '{1'b1, r_doc[best_idx], best_w, r_left == CW'(1), 1'b0};
                    if (r_left == CW'(1)) begin
                        o_q_pop = 1'b1;
                        n_st    = plmr_pkg::ST_RESP;
                    end
                end
            end
            default: n_st = plmr_pkg::ST_IDLE;
        endcase
    end

    // result valid follows r_vld, which marks an unconsumed result
    logic r_vld;
    assign m_out.valid = r_vld;
    assign m_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (do_merge) begin
            r_wt[hit_idx] <= plmr_pkg::sat_combine(r_wt[hit_idx], i_q_item.weight);
        end
        if (do_ins) begin
            if (!lt[0]) begin
                r_doc[0] <= i_q_item.doc_id;
                r_wt[0]  <= i_q_item.weight;
            end
            for (int i = 1; i < MAX_ENTRIES; i++) begin
                if (lt[i-1] && !lt[i]) begin
                    r_doc[i] <= i_q_item.doc_id;
                    r_wt[i]  <= i_q_item.weight;
                end else if (!lt[i]) begin
                    r_doc[i] <= r_doc[i-1];
                    r_wt[i]  <= r_wt[i-1];
                end
            end
        end
        if (!i_rst_n) begin
            r_st   <= plmr_pkg::ST_IDLE;
            r_cnt  <= '0;
            r_left <= '0;
            r_used <= '0;
            r_vld  <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_vld && m_out.ready) r_vld <= 1'b0;
            if (do_ins) r_cnt <= r_cnt + CW'(1);
            if (r_st == plmr_pkg::ST_IDLE && n_st != plmr_pkg::ST_IDLE) begin
                r_vld  <= (n_st == plmr_pkg::ST_RESP);
                r_left <= r_cnt;
                r_used <= '0;
            end
            if (r_st == plmr_pkg::ST_SCAN && take) begin
                r_vld            <= 1'b1;
                r_used[best_idx] <= 1'b1;
                r_left           <= r_left - CW'(1);
                if (r_left == CW'(1)) r_cnt <= '0;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_ENTRIES)) else $error("entry count overrun");
    a_ins_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ins |-> !full) else $error("insert into full store");
    a_merge_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(do_ins && do_merge)) else $error("insert and combine together");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> $stable(m_out.data))
        else $error("result changed while stalled");
`endif
endmodule
